[hw/rtl/rqns_pkg.sv]
// shared types, field widths and command and status codes of the ring queue
package rqns_pkg;

    localparam int WORD_W = 32;
    localparam int DATA_W = 36;
    localparam int ACC_W  = 37;
    localparam int CNT_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SUM  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_COUNT = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[hw/rtl/rqns_cell.sv]
// one storage cell of the queue row: holds a word, takes its neighbor's or a new one
module rqns_cell
    import rqns_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] load_data,
    input  logic [WORD_W-1:0] nbr_data,
    output logic [WORD_W-1:0] value
);

    logic [WORD_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= nbr_data;
        end
        else if (ctrl.load)
        begin
            value_reg <= load_data;
        end
    end

    assign value = value_reg;

endmodule

[hw/rtl/ring_queue_with_newest_sum.sv]
// top level of the ring queue with a newest-entries sum
// Entries live in a row of DEPTH cells, oldest in cell 0. Enqueue, dequeue and peek
// answer directly: start is accepted while busy is low and the result beat appears on
// done in the next cycle, and a new command may be started in that same cycle. A sum
// of the newest N entries rotates the whole cell row once, one word past the
// accumulator per cycle, so it keeps busy high while it runs and its beat appears on
// done in the cycle busy falls. Each result beat is on the ports for one cycle only
// and is not held, so the receiver must take it then. A write of cfg_wdata by cfg_we
// sets the capacity in use and empties the queue; write it only while no command is
// in flight.
module ring_queue_with_newest_sum
    import rqns_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [WORD_W-1:0] operand,
    input  logic                     cfg_we,
    input  logic [CNT_W-1:0]         cfg_wdata,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] data,
    output logic [CNT_W-1:0]         occupancy,
    output logic                     is_empty,
    output logic                     is_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MAX = (DEPTH > 31) ? CNT_W'(31) : CNT_W'(DEPTH);
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SUM  = 1'b1;

    logic [0:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cap_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     done_reg, done_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]         occ_reg;
    logic                     empty_reg, full_reg;

    logic [CNT_W-1:0]         cap_eff;
    logic                     shift_all;
    logic                     enq_load;
    logic                     in_range;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [DATA_W-1:0] acc_sat;
    logic signed [DATA_W-1:0] head_word;
    logic [WORD_W-1:0]        cell_val [DEPTH];

    assign cap_eff = (cap_reg == '0) ? CNT_W'(1) :
                     ((cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);

    // cell row, rotating toward cell 0
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        cell_ctrl_t ctrl;

        assign ctrl.shift = shift_all;
        assign ctrl.load  = enq_load && (32'(count_reg) == k);

        rqns_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_data (operand),
            .nbr_data  (cell_val[(k + 1) % DEPTH]),
            .value     (cell_val[k])
        );
    end

    assign head_word = {{(DATA_W-WORD_W){cell_val[0][WORD_W-1]}}, cell_val[0]};
    assign in_range  = (32'(step_reg) >= 32'(lo_reg)) && (32'(step_reg) < 32'(count_reg));
    assign term      = in_range ? {{(ACC_W-WORD_W){cell_val[0][WORD_W-1]}}, cell_val[0]}
                                : '0;
    assign acc_sum   = acc_reg + term;
    assign acc_sat   = (acc_sum[ACC_W-1] != acc_sum[ACC_W-2]) ?
                       (acc_sum[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}}) :
                       acc_sum[DATA_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        lo_next     = lo_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        status_next = STAT_OK;
        data_next   = '0;
        shift_all   = 1'b0;
        enq_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (cmd) inside
                        CMD_ENQ:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                enq_load   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQ, CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                data_next = head_word;
                                if (cmd == CMD_DEQ)
                                begin
                                    shift_all  = 1'b1;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        CMD_SUM:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (operand > $signed(32'(count_reg)))
                            begin
                                status_next = STAT_COUNT;
                            end
                            else if (operand > 0)
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SUM;
                                step_next  = '0;
                                lo_next    = count_reg - operand[CNT_W-1:0];
                                acc_next   = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                shift_all = 1'b1;
                acc_next  = acc_sum;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    done_next  = 1'b1;
                    data_next  = acc_sat;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CNT_W'(16);
            count_reg <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        occ_reg    <= count_next;
        empty_reg  <= (count_next == '0);
        full_reg   <= (count_next == cap_eff);
    end

    assign busy      = (state_reg == ST_SUM);
    assign done      = done_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign occupancy = occ_reg;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

endmodule

[hw/rtl/rqns_checker.sv]
// port-level checks on the ring queue and the bind that attaches them
module rqns_checker
    import rqns_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [CMD_W-1:0]         cmd,
    input logic                     done,
    input logic [STAT_W-1:0]        status,
    input logic signed [DATA_W-1:0] data,
    input logic [CNT_W-1:0]         occupancy,
    input logic                     is_empty,
    input logic                     is_full
);

    // enqueue, dequeue and peek answer in the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_SUM) |=> done)
        else $error("single-cycle command gave no result beat");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_empty && is_full))
        else $error("queue reported both empty and full");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (data == '0 && is_empty))
        else $error("empty status with data or entries");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> is_full)
        else $error("full status without full flag");

endmodule

bind ring_queue_with_newest_sum rqns_checker u_rqns_checker (.*);
